@@ sv/svf_pkg.sv @@
// svf_pkg: widths, constants, types and helper functions of the state-variable filter stage
// standalone: no dependencies; imported by every svf module and by the top level
`default_nettype none

package svf_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_FRAC_BITS  = 18;
    localparam int TAN_TABLE_DEPTH = 256;
    localparam int TAN_IDX_W       = $clog2(TAN_TABLE_DEPTH);
    localparam int ROM_W           = 26;

    localparam int RATE_W = 20;
    localparam int CUT_W  = 19;
    localparam int QV_W   = 16;

    localparam int G_W   = 22;
    localparam int K_W   = 20;
    localparam int A_W   = 19;
    localparam int DEN_W = 24;
    localparam int FR_W  = 17;
    localparam int POS_W = 24;
    localparam int WIDE_W = 40;

    localparam int DIV_N_W   = 44;
    localparam int DIV_D_W   = 24;
    localparam int DIV_CNT_W = 6;

    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 22;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    localparam logic [RATE_W-1:0] RATE_RESET = 20'd88200;
    localparam logic [RATE_W-1:0] RATE_MIN   = 20'd8000;
    localparam logic [RATE_W-1:0] RATE_MAX   = 20'd768000;
    localparam logic [QV_W-1:0]   Q_MIN      = 16'd1434;
    localparam logic [QV_W-1:0]   Q_MAX      = 16'd32768;
    localparam logic [CUT_W-1:0]  CUT_MIN    = 19'd10;
    localparam logic [DIV_D_W-1:0] LIM_DEN   = 24'd100;

    localparam logic [TAN_IDX_W-1:0] IDX_LAST = TAN_IDX_W'(TAN_TABLE_DEPTH - 2);
    localparam logic [FR_W-1:0]      FR_FULL  = 17'h10000;
    localparam logic [DEN_W-1:0]     COEF_ONE = DEN_W'(1 << COEF_FRAC_BITS);

    localparam logic signed [36:0] INT_HI = 37'sd2147483647;
    localparam logic signed [36:0] INT_LO = -37'sd2147483648;

    // numerator length of each divide, numerators are left aligned in the divider
    localparam logic [DIV_CNT_W-1:0] LEN_LIM = 6'd25;
    localparam logic [DIV_CNT_W-1:0] LEN_POS = 6'd44;
    localparam logic [DIV_CNT_W-1:0] LEN_K   = 6'd31;
    localparam logic [DIV_CNT_W-1:0] LEN_A1  = 6'd37;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] len;
    } svf_div_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_POS,
        ST_ROM,
        ST_INTERP,
        ST_KDIV,
        ST_GGK,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_FIN
    } svf_state_t;

    // long division by shift and subtract, only used while the table is elaborated
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        begin
            rem = '0;
            quo = '0;
            for (b = 63; b >= 0; b--) begin
                rem = {rem[63:0], num[b]};
                if (rem >= {1'b0, den}) begin
                    rem    = rem - {1'b0, den};
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // tan(pi*i/(2*depth)) in coefficient format, series of sin and cos at 30 fraction bits
    function automatic logic [ROM_W-1:0] tan_entry(input int idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] su;
        logic [63:0] cu;
        longint      s;
        longint      c;
        int          n;
        begin
            x  = (PI_Q30 * 64'(idx)) / 64'(2 * TAN_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            s  = longint'(x);
            c  = longint'(64'd1 << 30);
            ts = x;
            tc = 64'd1 << 30;
            for (n = 1; n <= 12; n++) begin
                ts = div_u64((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                tc = div_u64((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
                if (n[0]) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end
                else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) s = 0;
            if (c < 1) c = 1;
            su = 64'(s);
            cu = 64'(c);
            return ROM_W'(div_u64((su << COEF_FRAC_BITS) + (cu >> 1), cu));
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        begin
            hi = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - WIDE_W'(1);
            lo = -hi - WIDE_W'(1);
            if (v > hi) return hi[SAMPLE_BITS-1:0];
            if (v < lo) return lo[SAMPLE_BITS-1:0];
            return v[SAMPLE_BITS-1:0];
        end
    endfunction

    function automatic logic [MUL_A_W-1:0] mag_of(input logic signed [MUL_A_W:0] v);
        logic signed [MUL_A_W:0] m;
        begin
            m = v[MUL_A_W] ? -v : v;
            return m[MUL_A_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/svf_tan_rom.sv @@
// svf_tan_rom: constant tangent table with two registered read ports (entry and next entry)
// depends on svf_pkg (tan_entry, table depth and width)
`default_nettype none

module svf_tan_rom import svf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic [TAN_IDX_W-1:0] idx,
    output logic      [ROM_W-1:0]     t0_data,
    output logic      [ROM_W-1:0]     t1_data
);

    logic [ROM_W-1:0]     rom [TAN_TABLE_DEPTH];
    logic [TAN_IDX_W-1:0] idx_up;
    logic [ROM_W-1:0]     t0_reg;
    logic [ROM_W-1:0]     t1_reg;

    for (genvar i = 0; i < TAN_TABLE_DEPTH; i++) begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = tan_entry(i);
        assign rom[i] = ENTRY;
    end

    assign idx_up = idx + TAN_IDX_W'(1);

    always_ff @(posedge clk)
    begin
        t0_reg <= rom[idx];
        t1_reg <= rom[idx_up];
    end

    assign t0_data = t0_reg;
    assign t1_data = t1_reg;

endmodule

`default_nettype wire

@@ sv/svf_div.sv @@
// svf_div: restoring divider, one quotient bit per cycle, left-aligned numerator
// depends on svf_pkg (svf_div_ctl_t, divider widths)
`default_nettype none

module svf_div import svf_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire svf_div_ctl_t       ctl,
    input  wire logic [DIV_N_W-1:0] num,
    input  wire logic [DIV_D_W-1:0] den,
    output logic                    done,
    output logic      [DIV_N_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W:0]     shifted;
    logic                 fits;
    logic [DIV_D_W:0]     rem_next;

    assign shifted  = {rem_reg, num_reg[DIV_N_W-1]};
    assign fits     = shifted >= {1'b0, den_reg};
    assign rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.len;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in at the bottom as numerator bits leave the top
    always_ff @(posedge clk)
    begin
        if (ctl.start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg) begin
            num_reg <= {num_reg[DIV_N_W-2:0], fits};
            rem_reg <= rem_next[DIV_D_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire

@@ sv/svf_mul.sv @@
// svf_mul: unsigned shift-add multiplier, one multiplier bit per cycle
// depends on svf_pkg (multiplier widths)
`default_nettype none

module svf_mul import svf_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic      [MUL_P_W-1:0] prod
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_A_W:0]     sum;

    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
               + (prod_reg[0] ? {1'b0, a_reg} : {(MUL_A_W + 1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // multiplier bits leave at the bottom while the partial sum grows at the top
    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, b};
        end
        else if (busy_reg) begin
            prod_reg <= {sum, prod_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ sv/state_variable_filter_stage_unit.sv @@
// one sample at a time: sample_stall is high from an accepted sample beat until its result
// is registered, including while the finished result waits for the previous one to be taken
// each sample takes serial divides of 25, 44, 31 and 37 bits and nine 22-bit serial multiplies
// a finished result waits in an output register while the next sample is taken
// reset clears both integrators, the control state and sets the sample rate to 88200
// top level of the filter stage; depends on svf_pkg, svf_div, svf_mul and svf_tan_rom
`default_nettype none

module state_variable_filter_stage_unit import svf_pkg::*; (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_rate_we,
    input  wire logic        [RATE_W-1:0]      sample_rate_wdata,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic        [CUT_W-1:0]       cutoff_hz,
    input  wire logic        [QV_W-1:0]        q_value,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed      [SAMPLE_BITS-1:0] low_out,
    output logic signed      [SAMPLE_BITS-1:0] band_out,
    output logic signed      [SAMPLE_BITS-1:0] high_out,
    output logic                               overflow_cleared
);

    svf_state_t state_reg;
    svf_state_t state_next;
    logic       launch_reg;
    logic       launch_next;

    logic [RATE_W-1:0] sr_reg;
    logic [RATE_W-1:0] sr_cl;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CUT_W-1:0]     c_reg;
    logic [QV_W-1:0]      q_reg;
    logic [TAN_IDX_W-1:0] idx_reg;
    logic [FR_W-1:0]      fr_reg;
    logic [G_W-1:0]       g_reg;
    logic [K_W-1:0]       k_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [A_W-1:0]       a1_reg;
    logic [A_W-1:0]       a2_reg;
    logic [A_W-1:0]       a3_reg;
    logic signed [34:0]   v1_reg;
    logic signed [34:0]   v2_reg;
    logic signed [WIDE_W-1:0] hp_reg;
    logic signed [31:0]   int1_reg;
    logic signed [31:0]   int2_reg;

    logic signed [SAMPLE_BITS-1:0] low_reg;
    logic signed [SAMPLE_BITS-1:0] band_reg;
    logic signed [SAMPLE_BITS-1:0] high_reg;
    logic                          ovf_out_reg;
    logic                          result_valid_reg;

    svf_div_ctl_t       div_ctl;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_neg;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    logic [37:0]        mul_sh;
    logic signed [38:0] mul_s;

    logic [ROM_W-1:0]   t0;
    logic [ROM_W-1:0]   t1;
    logic [ROM_W-1:0]   rom_diff;
    logic [ROM_W:0]     interp_sum;

    logic [24:0]        lim_num;
    logic [30:0]        k_num;
    logic [36:0]        a1_num;
    logic [POS_W-1:0]   pos;
    logic signed [32:0] v3;
    logic signed [36:0] n1;
    logic signed [36:0] n2;
    logic               ovf;
    logic               out_free;
    logic               fire_out;
    logic               accept;

    svf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    svf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    svf_tan_rom u_rom (
        .clk     (clk),
        .idx     (idx_reg),
        .t0_data (t0),
        .t1_data (t1)
    );

    assign sr_cl = (sr_reg < RATE_MIN) ? RATE_MIN : ((sr_reg > RATE_MAX) ? RATE_MAX : sr_reg);

    // rate * 42 by shifts
    assign lim_num = ({5'b0, sr_cl} << 5) + ({5'b0, sr_cl} << 3) + ({5'b0, sr_cl} << 1);
    assign k_num   = (31'd1 << 30) + 31'(q_reg >> 1);
    assign a1_num  = (37'd1 << 36) + 37'(den_reg >> 1);
    assign pos     = div_quo[POS_W-1:0];

    assign rom_diff   = (t1 >= t0) ? (t1 - t0) : '0;
    assign interp_sum = {1'b0, t0} + {1'b0, mul_prod[16 +: ROM_W]};

    assign mul_sh = mul_prod[COEF_FRAC_BITS +: 38];
    assign mul_s  = mul_neg ? -$signed({1'b0, mul_sh}) : $signed({1'b0, mul_sh});

    assign v3  = 33'(x_reg) - 33'(int2_reg);
    assign n1  = 37'(v1_reg) + 37'(v1_reg) - 37'(int1_reg);
    assign n2  = 37'(v2_reg) + 37'(v2_reg) - 37'(int2_reg);
    assign ovf = (n1 > INT_HI) || (n1 < INT_LO) || (n2 > INT_HI) || (n2 < INT_LO);

    assign out_free = !result_valid_reg || !result_stall;
    assign fire_out = (state_reg == ST_FIN) && out_free;
    assign accept   = sample_valid && (state_reg == ST_IDLE);

    assign sample_stall     = (state_reg != ST_IDLE);
    assign result_valid     = result_valid_reg;
    assign low_out          = low_reg;
    assign band_out         = band_reg;
    assign high_out         = high_reg;
    assign overflow_cleared = ovf_out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (sample_valid) state_next = ST_LIM;
            ST_LIM:    if (div_done) state_next = ST_POS;
            ST_POS:    if (div_done) state_next = ST_ROM;
            ST_ROM:    state_next = ST_INTERP;
            ST_INTERP: if (mul_done) state_next = ST_KDIV;
            ST_KDIV:   if (div_done) state_next = ST_GGK;
            ST_GGK:    if (mul_done) state_next = ST_A1;
            ST_A1:     if (div_done) state_next = ST_A2;
            ST_A2:     if (mul_done) state_next = ST_A3;
            ST_A3:     if (mul_done) state_next = ST_M1;
            ST_M1:     if (mul_done) state_next = ST_M2;
            ST_M2:     if (mul_done) state_next = ST_M3;
            ST_M3:     if (mul_done) state_next = ST_M4;
            ST_M4:     if (mul_done) state_next = ST_M5;
            ST_M5:     if (mul_done) state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign launch_next = (state_next != state_reg);

    // unit operands per step
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.len   = LEN_LIM;
        div_num       = '0;
        div_den       = '0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        mul_neg       = 1'b0;
        unique case (state_reg)
            ST_LIM: begin
                div_ctl.start = launch_reg;
                div_ctl.len   = LEN_LIM;
                div_num       = {lim_num, 19'b0};
                div_den       = LIM_DEN;
            end
            ST_POS: begin
                div_ctl.start = launch_reg;
                div_ctl.len   = LEN_POS;
                div_num       = {c_reg, 25'b0};
                div_den       = DIV_D_W'(sr_cl);
            end
            ST_INTERP: begin
                mul_start = launch_reg;
                mul_a     = MUL_A_W'(rom_diff);
                mul_b     = MUL_B_W'(fr_reg);
            end
            ST_KDIV: begin
                div_ctl.start = launch_reg;
                div_ctl.len   = LEN_K;
                div_num       = {k_num, 13'b0};
                div_den       = DIV_D_W'(q_reg);
            end
            ST_GGK: begin
                mul_start = launch_reg;
                mul_a     = MUL_A_W'({1'b0, g_reg} + {3'b0, k_reg});
                mul_b     = g_reg;
            end
            ST_A1: begin
                div_ctl.start = launch_reg;
                div_ctl.len   = LEN_A1;
                div_num       = {a1_num, 7'b0};
                div_den       = den_reg;
            end
            ST_A2: begin
                mul_start = launch_reg;
                mul_a     = MUL_A_W'(g_reg);
                mul_b     = MUL_B_W'(a1_reg);
            end
            ST_A3: begin
                mul_start = launch_reg;
                mul_a     = MUL_A_W'(g_reg);
                mul_b     = MUL_B_W'(a2_reg);
            end
            ST_M1: begin
                mul_start = launch_reg;
                mul_a     = mag_of(35'(int1_reg));
                mul_b     = MUL_B_W'(a1_reg);
                mul_neg   = int1_reg[31];
            end
            ST_M2: begin
                mul_start = launch_reg;
                mul_a     = mag_of(35'(v3));
                mul_b     = MUL_B_W'(a2_reg);
                mul_neg   = v3[32];
            end
            ST_M3: begin
                mul_start = launch_reg;
                mul_a     = mag_of(35'(int1_reg));
                mul_b     = MUL_B_W'(a2_reg);
                mul_neg   = int1_reg[31];
            end
            ST_M4: begin
                mul_start = launch_reg;
                mul_a     = mag_of(35'(v3));
                mul_b     = MUL_B_W'(a3_reg);
                mul_neg   = v3[32];
            end
            ST_M5: begin
                mul_start = launch_reg;
                mul_a     = mag_of(v1_reg);
                mul_b     = MUL_B_W'(k_reg);
                mul_neg   = v1_reg[34];
            end
            ST_IDLE, ST_ROM, ST_FIN: begin
                mul_start = 1'b0;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            launch_reg       <= 1'b0;
            sr_reg           <= RATE_RESET;
            int1_reg         <= '0;
            int2_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (sample_rate_we) begin
                sr_reg <= sample_rate_wdata;
            end
            if (fire_out) begin
                int1_reg <= ovf ? 32'sd0 : n1[31:0];
                int2_reg <= ovf ? 32'sd0 : n2[31:0];
            end
            if (fire_out) begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath captures: inputs on accept, then one per unit step as it finishes, results on fire_out
    always_ff @(posedge clk)
    begin
        if (accept) begin
            x_reg <= sample_in;
            c_reg <= (cutoff_hz < CUT_MIN) ? CUT_MIN : cutoff_hz;
            q_reg <= (q_value < Q_MIN) ? Q_MIN : ((q_value > Q_MAX) ? Q_MAX : q_value);
        end
        if (state_reg == ST_LIM && div_done) begin
            if (c_reg > div_quo[CUT_W-1:0]) begin
                c_reg <= div_quo[CUT_W-1:0];
            end
        end
        if (state_reg == ST_POS && div_done) begin
            if (pos[POS_W-1:16] > IDX_LAST) begin
                idx_reg <= IDX_LAST;
                fr_reg  <= FR_FULL;
            end
            else begin
                idx_reg <= pos[POS_W-1:16];
                fr_reg  <= {1'b0, pos[15:0]};
            end
        end
        if (state_reg == ST_INTERP && mul_done) begin
            g_reg <= interp_sum[G_W-1:0];
        end
        if (state_reg == ST_KDIV && div_done) begin
            k_reg <= div_quo[K_W-1:0];
        end
        if (state_reg == ST_GGK && mul_done) begin
            den_reg <= COEF_ONE + mul_prod[COEF_FRAC_BITS +: DEN_W];
        end
        if (state_reg == ST_A1 && div_done) begin
            a1_reg <= div_quo[A_W-1:0];
        end
        if (state_reg == ST_A2 && mul_done) begin
            a2_reg <= mul_prod[COEF_FRAC_BITS +: A_W];
        end
        if (state_reg == ST_A3 && mul_done) begin
            a3_reg <= mul_prod[COEF_FRAC_BITS +: A_W];
        end
        if (state_reg == ST_M1 && mul_done) begin
            v1_reg <= 35'(mul_s);
        end
        if (state_reg == ST_M2 && mul_done) begin
            v1_reg <= v1_reg + 35'(mul_s);
        end
        if (state_reg == ST_M3 && mul_done) begin
            v2_reg <= 35'(int2_reg) + 35'(mul_s);
        end
        if (state_reg == ST_M4 && mul_done) begin
            v2_reg <= v2_reg + 35'(mul_s);
        end
        if (state_reg == ST_M5 && mul_done) begin
            hp_reg <= WIDE_W'(x_reg) - WIDE_W'(mul_s) - WIDE_W'(v2_reg);
        end
        if (fire_out) begin
            if (ovf) begin
                low_reg     <= '0;
                band_reg    <= '0;
                high_reg    <= '0;
                ovf_out_reg <= 1'b1;
            end
            else begin
                low_reg     <= sat_sample(WIDE_W'(v2_reg));
                band_reg    <= sat_sample(WIDE_W'(v1_reg));
                high_reg    <= sat_sample(hp_reg);
                ovf_out_reg <= 1'b0;
            end
        end
    end

    a_div_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_LIM || state_reg == ST_POS ||
                      state_reg == ST_KDIV || state_reg == ST_A1))
        else $error("divider finished outside a divide step");

    a_mul_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> !(state_reg == ST_IDLE || state_reg == ST_LIM || state_reg == ST_POS ||
                       state_reg == ST_ROM || state_reg == ST_KDIV || state_reg == ST_A1 ||
                       state_reg == ST_FIN))
        else $error("multiplier finished outside a multiply step");

    a_ovf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_out && ovf) |=> (int1_reg == 32'sd0 && int2_reg == 32'sd0 && overflow_cleared))
        else $error("integrator overflow did not clear state");

    a_fin_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fire_out |=> (result_valid && state_reg == ST_IDLE))
        else $error("finished item did not produce a result beat");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for the state-variable filter stage, with its own filter predictor
// depends on svf_pkg and state_variable_filter_stage_unit; checks every result beat in order
`timescale 1ns / 1ps

module tb import svf_pkg::*; ();

    localparam int LATENCY     = 364;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] lp;
        logic signed [SAMPLE_BITS-1:0] bp;
        logic signed [SAMPLE_BITS-1:0] hp;
        logic                          ovf;
    } filt_out_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic        [CUT_W-1:0]       cut;
        logic        [QV_W-1:0]        qv;
        bit                            typed;
        filt_out_t                     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_rate_we = 1'b0;
    logic [RATE_W-1:0] sample_rate_wdata = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic [CUT_W-1:0] cutoff_hz = '0;
    logic [QV_W-1:0] q_value = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] low_out;
    logic signed [SAMPLE_BITS-1:0] band_out;
    logic signed [SAMPLE_BITS-1:0] high_out;
    logic overflow_cleared;

    state_variable_filter_stage_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_rate_we    (sample_rate_we),
        .sample_rate_wdata (sample_rate_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample_in         (sample_in),
        .cutoff_hz         (cutoff_hz),
        .q_value           (q_value),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .low_out           (low_out),
        .band_out          (band_out),
        .high_out          (high_out),
        .overflow_cleared  (overflow_cleared)
    );

    always #4 clk = ~clk;

    // predictor state
    longint unsigned tan_tbl [TAN_TABLE_DEPTH];
    logic [RATE_W-1:0] rate_reg = RATE_RESET;
    longint integ_one = 0;
    longint integ_two = 0;

    filt_out_t filter_outputs_due [$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    function automatic void build_tan_tbl();
        longint unsigned x, x2, ts, tc, n;
        longint s, c;
        for (int i = 0; i < TAN_TABLE_DEPTH; i++) begin
            x  = (64'd3373259426 * longint'(i)) / (2 * TAN_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            s  = longint'(x);
            c  = longint'(1) << 30;
            ts = x;
            tc = 64'd1 << 30;
            for (n = 1; n <= 12; n++) begin
                ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
                tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
                if (n[0]) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end
                else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) s = 0;
            if (c < 1) c = 1;
            tan_tbl[i] = ((longint'(s) << COEF_FRAC_BITS) + longint'(c) / 2) / longint'(c);
        end
    endfunction

    // floor(a*b / 2^frac) split so the partial products stay in 64 bits
    function automatic longint unsigned coef_mul(longint unsigned a, longint unsigned b);
        longint unsigned m, ah, al, bh, bl;
        m  = (64'd1 << COEF_FRAC_BITS) - 1;
        ah = a >> COEF_FRAC_BITS;
        al = a & m;
        bh = b >> COEF_FRAC_BITS;
        bl = b & m;
        return ((ah * bh) << COEF_FRAC_BITS) + ah * bl + al * bh + ((al * bl) >> COEF_FRAC_BITS);
    endfunction

    function automatic longint sig_mul(longint v, longint unsigned c);
        longint unsigned mag, p;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        p = coef_mul(mag, c);
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip(longint v);
        longint hi, lo;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -(longint'(1) << (SAMPLE_BITS - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic filt_out_t svf_predict(logic signed [SAMPLE_BITS-1:0] smp,
                                              logic [CUT_W-1:0] cut, logic [QV_W-1:0] qv);
        longint unsigned one, sr, lim, c, q, pos, idx, fr, t0, t1, g, k, den, a1, a2, a3;
        longint x, v3, v1, v2, n1, n2, hp;
        filt_out_t r;
        one = 64'd1 << COEF_FRAC_BITS;
        sr = 64'(rate_reg);
        if (sr < 8000) sr = 8000;
        if (sr > 768000) sr = 768000;
        x = longint'(smp);
        c = 64'(cut);
        lim = (sr * 42) / 100;
        if (c < 10) c = 10;
        if (c > lim) c = lim;
        q = 64'(qv);
        if (q < 1434) q = 1434;
        if (q > 32768) q = 32768;
        pos = ((c * 2 * TAN_TABLE_DEPTH) << 16) / sr;
        idx = pos >> 16;
        fr = pos & 64'hFFFF;
        if (idx > TAN_TABLE_DEPTH - 2) begin
            idx = TAN_TABLE_DEPTH - 2;
            fr = 64'h10000;
        end
        t0 = tan_tbl[idx];
        t1 = tan_tbl[idx + 1];
        g = t0 + (((t1 >= t0) ? t1 - t0 : 0) * fr >> 16);
        k = ((one << 12) + q / 2) / q;
        den = one + coef_mul(g, g + k);
        a1 = ((one << COEF_FRAC_BITS) + den / 2) / den;
        a2 = coef_mul(g, a1);
        a3 = coef_mul(g, a2);
        v3 = x - integ_two;
        v1 = sig_mul(integ_one, a1) + sig_mul(v3, a2);
        v2 = integ_two + sig_mul(integ_one, a2) + sig_mul(v3, a3);
        n1 = 2 * v1 - integ_one;
        n2 = 2 * v2 - integ_two;
        if (n1 > 64'sd2147483647 || n1 < -64'sd2147483648 ||
            n2 > 64'sd2147483647 || n2 < -64'sd2147483648) begin
            integ_one = 0;
            integ_two = 0;
            r.lp = '0;
            r.bp = '0;
            r.hp = '0;
            r.ovf = 1'b1;
            return r;
        end
        integ_one = n1;
        integ_two = n2;
        hp = x - sig_mul(v1, k) - v2;
        r.lp = clip(v2);
        r.bp = clip(v1);
        r.hp = clip(hp);
        r.ovf = 1'b0;
        return r;
    endfunction

    // one sample beat; valid stays high across a burst
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic [CUT_W-1:0] cut,
                               logic [QV_W-1:0] qv, bit typed, filt_out_t want);
        int gap;
        filt_out_t got;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample_in <= smp;
        cutoff_hz <= cut;
        q_value <= qv;
        do @(posedge clk); while (sample_stall);
        got = svf_predict(smp, cut, qv);
        filter_outputs_due.push_back(typed ? want : got);
    endtask

    task automatic drain_and_set_rate(logic [RATE_W-1:0] rate);
        sample_valid <= 1'b0;
        burst_left = 0;
        while (filter_outputs_due.size() > 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        sample_rate_we <= 1'b1;
        sample_rate_wdata <= rate;
        @(posedge clk);
        sample_rate_we <= 1'b0;
        rate_reg = rate;
    endtask

    task automatic random_phase(int n_items);
        int left, run, period, amp, ph;
        logic [CUT_W-1:0] cut;
        logic [QV_W-1:0] qv;
        filt_out_t none;
        none = '{default: '0};
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: every field drawn over its full width
                send_sample(SAMPLE_BITS'($urandom), CUT_W'($urandom), QV_W'($urandom),
                            1'b0, none);
                left--;
            end
            else begin
                // audio-like run: steady cutoff and Q, square or random content
                run = $urandom_range(10, 40);
                cut = ($urandom_range(0, 2) == 0) ? CUT_W'($urandom_range(0, 2000))
                                                  : CUT_W'($urandom_range(0, 400000));
                qv = ($urandom_range(0, 1) == 0) ? QV_W'($urandom_range(20000, 65535))
                                                 : QV_W'($urandom);
                period = $urandom_range(2, 64);
                amp = $urandom_range(1000, 8388607);
                for (ph = 0; ph < run && left > 0; ph++) begin
                    if ($urandom_range(0, 2) == 0)
                        send_sample(SAMPLE_BITS'($urandom), cut, qv, 1'b0, none);
                    else
                        send_sample(SAMPLE_BITS'(((ph % period) < period / 2) ? amp : -amp - 1),
                                    cut, qv, 1'b0, none);
                    left--;
                end
            end
        end
    endtask

    // receiver stall pattern: modes of varying density, including no stall at all
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 3000);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 1) == 0);
            default: result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk) begin
        filt_out_t e;
        if (result_valid && !result_stall) begin
            if (filter_outputs_due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end
            else begin
                e = filter_outputs_due.pop_front();
                if (low_out !== e.lp) begin
                    $error("low_out expected %0d got %0d", e.lp, low_out);
                    errors++;
                end
                if (band_out !== e.bp) begin
                    $error("band_out expected %0d got %0d", e.bp, band_out);
                    errors++;
                end
                if (high_out !== e.hp) begin
                    $error("high_out expected %0d got %0d", e.hp, high_out);
                    errors++;
                end
                if (overflow_cleared !== e.ovf) begin
                    $error("overflow_cleared expected %0d got %0d", e.ovf, overflow_cleared);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = -24'sh800000;

    stim_row_t directed [] = '{
        // silence after reset: everything stays at zero
        '{24'sd0,   19'd1000,   16'd4096,  1'b1, '{24'sd0, 24'sd0, 24'sd0, 1'b0}},
        '{S_MAX,    19'd1000,   16'd4096,  1'b0, '{default: '0}},
        '{S_MIN,    19'd1000,   16'd4096,  1'b0, '{default: '0}},
        '{S_MAX,    19'd0,      16'd4096,  1'b0, '{default: '0}},
        '{S_MIN,    19'd9,      16'd4096,  1'b0, '{default: '0}},
        '{S_MAX,    19'd10,     16'd4096,  1'b0, '{default: '0}},
        '{S_MIN,    19'd400000, 16'd4096,  1'b0, '{default: '0}},
        '{S_MAX,    19'h7FFFF,  16'd4096,  1'b0, '{default: '0}},
        '{S_MIN,    19'd37044,  16'd4096,  1'b0, '{default: '0}},
        '{S_MAX,    19'd37045,  16'd0,     1'b0, '{default: '0}},
        '{S_MIN,    19'd20000,  16'd1433,  1'b0, '{default: '0}},
        '{S_MAX,    19'd20000,  16'd1434,  1'b0, '{default: '0}},
        '{S_MIN,    19'd20000,  16'd32768, 1'b0, '{default: '0}},
        '{S_MAX,    19'd20000,  16'd32769, 1'b0, '{default: '0}},
        '{S_MIN,    19'd20000,  16'hFFFF,  1'b0, '{default: '0}},
        '{S_MAX,    19'd20000,  16'hFFFF,  1'b0, '{default: '0}},
        '{S_MIN,    19'd20000,  16'hFFFF,  1'b0, '{default: '0}},
        '{24'sd1,   19'd5000,   16'd2896,  1'b0, '{default: '0}},
        '{-24'sd1,  19'd5000,   16'd2896,  1'b0, '{default: '0}},
        '{24'sh555555, 19'h2AAAA, 16'h5555, 1'b0, '{default: '0}},
        '{-24'sh2AAAAB, 19'h55555, 16'hAAAA, 1'b0, '{default: '0}}
    };

    logic [RATE_W-1:0] rates [] = '{20'd8000, 20'd768000, 20'd0, 20'hFFFFF, 20'd44100,
                                    20'd7999, 20'd768001, 20'd192000};

    initial begin
        build_tan_tbl();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_sample(directed[i].smp, directed[i].cut, directed[i].qv, directed[i].typed,
                        directed[i].want);
        random_phase(130);
        foreach (rates[i]) begin
            drain_and_set_rate(rates[i]);
            random_phase(100);
        end
        drain_and_set_rate(RATE_W'($urandom));
        random_phase(100);
        sample_valid <= 1'b0;
        while (filter_outputs_due.size() > 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/svf_pkg.sv
sv/svf_tan_rom.sv
sv/svf_div.sv
sv/svf_mul.sv
sv/state_variable_filter_stage_unit.sv
bench/tb.sv
